// ===== design/jbu_pkg.sv =====
// Package for the JPEG block upsampler: item, command and result types,
// register index codes, back-end states and small arithmetic helpers.
// Depends on nothing; every other file of the block but jbu_fifo uses it.
package jbu_pkg;

  // Fixed geometry of one JPEG block.
  localparam int BLOCK_SIDE          = 8;
  localparam int MAX_BLOCKS_PER_SIDE = 4;
  localparam int STORE_DEPTH         = 1024;
  localparam int ADDR_W              = 10;
  localparam int PIXEL_W             = 8;
  localparam int COUNT_W             = 3;
  localparam int ROW_W               = 5;
  localparam int SPAN_W              = 6;

  // Division by three for values below 32: multiply by 11, shift right by 5.
  localparam int RECIP3       = 11;
  localparam int RECIP3_SHIFT = 5;

  // Request codes carried in the mode field.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_IN_WIDE  = 2'd0,
    CFG_IN_HIGH  = 2'd1,
    CFG_OUT_WIDE = 2'd2,
    CFG_OUT_HIGH = 2'd3
  } cfg_reg_e_t;

  // Back-end sequencer states.
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } back_state_t;

  // One input beat.
  typedef struct packed {
    logic               mode;
    logic [PIXEL_W-1:0] pixel_in;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               row_end;
    logic               frame_end;
    logic               setup_error;
  } out_item_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic               is_emit;
    logic [PIXEL_W-1:0] pixel;
    logic               err;
    logic               rep;
    logic [COUNT_W-1:0] ch;
    logic [COUNT_W-1:0] cv;
    logic [SPAN_W-1:0]  width;
    logic [SPAN_W-1:0]  height;
    logic [COUNT_W-1:0] ih;
  } cmd_t;

  // Register value to block count: zero counts as one, above four as four.
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] res;
    if (v == '0) begin
      res = COUNT_W'(1);
    end else if (v > COUNT_W'(MAX_BLOCKS_PER_SIDE)) begin
      res = COUNT_W'(MAX_BLOCKS_PER_SIDE);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Quotient of a value below 32 by a divisor from one to four.
  function automatic logic [ROW_W-1:0] div_small(input logic [ROW_W-1:0] v,
                                                 input logic [COUNT_W-1:0] d);
    logic [ROW_W+3:0] prod;
    logic [ROW_W-1:0] res;
    prod = (ROW_W+4)'(v) * (ROW_W+4)'(RECIP3);
    case (d)
      3'd2:    res = v >> 1;
      3'd3:    res = ROW_W'(prod >> RECIP3_SHIFT);
      3'd4:    res = v >> 2;
      default: res = v;
    endcase
    return res;
  endfunction

endpackage

// ===== design/jpeg_block_upsampler_core.sv =====
// Top level of the JPEG block upsampler: front end, command queue, back end
// and result queue. Depends on jbu_pkg, jbu_front, jbu_fifo and jbu_back.
//
// Usage: load beats (mode 0) write one pixel each into a 1024-entry store in
// block order; an emit beat (mode 1) produces the next output row, one
// result beat per pixel, 8 to 32 beats, read out through the single read
// port of the pixel store and held back while the result queue has no room.
// If the input block counts exceed the output counts, an emit gives one beat
// with setup_error set instead. After the last row of a frame the row counter
// and the load address return to zero. A command queue decouples input from
// the store, and a one-beat read stage and a result queue decouple the store
// from the reader. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
module jpeg_block_upsampler_core #(
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  jbu_pkg::in_item_t           in_data,
  output logic                        empty,
  input  logic                        pop,
  output jbu_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [jbu_pkg::COUNT_W-1:0] cfg_wdata
);

  localparam int CMD_W = $bits(jbu_pkg::cmd_t);
  localparam int OUT_W = $bits(jbu_pkg::out_item_t);

  jbu_pkg::cmd_t                  cmd_in, cmd_out;
  logic                           cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
  logic [CMD_W-1:0]               cmd_out_bits;
  logic                           out_push, out_full;
  jbu_pkg::out_item_t             out_item;
  logic [OUT_W-1:0]               out_bits;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

  // Front end: configuration and request classification.
  jbu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  // Command queue between front and back.
  jbu_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out_bits),
    .empty   (cmd_empty),
    .count   (cmd_count)
  );

  assign cmd_out = jbu_pkg::cmd_t'(cmd_out_bits);

  // Back end: store and row sequencer.
  jbu_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty && (cmd_count == '0)),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_item  (out_item)
  );

  // Result queue toward the reader; the back end never pushes without room.
  jbu_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_push && !out_full),
    .wr_data (out_item),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_bits),
    .empty   (empty),
    .count   (out_count)
  );

  assign out_data = jbu_pkg::out_item_t'(out_bits);

endmodule

// ===== design/jbu_fifo.sv =====
// Small first-in first-out queue of flip-flops with an occupancy count.
// Used between front and back and as the result queue; no package needed.
module jbu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/jbu_front.sv =====
// Front end of the JPEG block upsampler: configuration registers, input
// acceptance and classification of each beat into a command. Uses jbu_pkg.
module jbu_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [jbu_pkg::COUNT_W-1:0]  cfg_wdata,
  input  logic                         push,
  output logic                         full,
  input  jbu_pkg::in_item_t            in_data,
  input  logic                         cmd_full,
  output logic                         cmd_push,
  output jbu_pkg::cmd_t                cmd
);

  logic [jbu_pkg::COUNT_W-1:0] in_wide_r, in_high_r, out_wide_r, out_high_r;
  logic [jbu_pkg::COUNT_W-1:0] ih, iv, oh, ov, ch, cv;
  logic                        rep;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;
  assign cmd_push  = push && !cmd_full;

  // Configuration registers keep the written bits; clamping happens on use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_wide_r  <= jbu_pkg::COUNT_W'(1);
      in_high_r  <= jbu_pkg::COUNT_W'(1);
      out_wide_r <= jbu_pkg::COUNT_W'(1);
      out_high_r <= jbu_pkg::COUNT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        jbu_pkg::CFG_IN_WIDE:  in_wide_r  <= cfg_wdata;
        jbu_pkg::CFG_IN_HIGH:  in_high_r  <= cfg_wdata;
        jbu_pkg::CFG_OUT_WIDE: out_wide_r <= cfg_wdata;
        jbu_pkg::CFG_OUT_HIGH: out_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame geometry: replication factors and output span.
  always_comb begin
    ih  = jbu_pkg::clamp_count(in_wide_r);
    iv  = jbu_pkg::clamp_count(in_high_r);
    oh  = jbu_pkg::clamp_count(out_wide_r);
    ov  = jbu_pkg::clamp_count(out_high_r);
    rep = (ih < oh) || (iv < ov);
    ch  = jbu_pkg::COUNT_W'(jbu_pkg::div_small(jbu_pkg::ROW_W'(oh), ih));
    cv  = jbu_pkg::COUNT_W'(jbu_pkg::div_small(jbu_pkg::ROW_W'(ov), iv));
  end

  // Command for the back end.
  always_comb begin
    cmd.is_emit = (in_data.mode == jbu_pkg::MODE_EMIT);
    cmd.pixel   = in_data.pixel_in;
    cmd.err     = (ih > oh) || (iv > ov);
    cmd.rep     = rep;
    cmd.ch      = ch;
    cmd.cv      = cv;
    cmd.width   = rep ? {ch, 3'b000} : {ih, 3'b000};
    cmd.height  = rep ? {cv, 3'b000} : {iv, 3'b000};
    cmd.ih      = ih;
  end

endmodule

// ===== design/jbu_back.sv =====
// Back end of the JPEG block upsampler: pixel store, load pointer, row
// counter and the column sequencer that emits one row. Uses jbu_pkg.
module jbu_back #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_empty,
  input  jbu_pkg::cmd_t                      cmd,
  output logic                               cmd_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
  output logic                               out_push,
  output jbu_pkg::out_item_t                 out_item
);

  localparam int CW = $clog2(OUT_DEPTH+1);
  localparam int AW = jbu_pkg::ADDR_W;
  localparam int RW = jbu_pkg::ROW_W;
  localparam int SW = jbu_pkg::SPAN_W;

  jbu_pkg::back_state_t state_r, state_nxt;

  logic [jbu_pkg::PIXEL_W-1:0] store_r [jbu_pkg::STORE_DEPTH];
  logic [jbu_pkg::PIXEL_W-1:0] rdata_r;

  logic [AW-1:0]               load_ptr_r, load_ptr_nxt;
  logic [RW-1:0]               out_row_r, out_row_nxt;
  logic [RW-1:0]               row_r, row_nxt;
  logic                        last_row_r, last_row_nxt;
  logic [SW-1:0]               width_r, width_nxt;
  logic                        rep_r, rep_nxt;
  logic [jbu_pkg::COUNT_W-1:0] ch_r, ch_nxt;
  logic [AW-1:0]               row_base_r, row_base_nxt;
  logic [RW-1:0]               col_r, col_nxt;
  logic                        s1_valid_r, s1_valid_nxt;
  logic                        s1_err_r, s1_err_nxt;
  logic                        s1_row_end_r, s1_row_end_nxt;
  logic                        s1_frame_end_r, s1_frame_end_nxt;

  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [CW:0]                 occ;
  logic                        space;
  logic [RW-1:0]               r_start, r_div, c_div;
  logic [RW-1:0]               blk;
  logic [AW-1:0]               col_off;
  logic                        col_last;

  // Room in the result queue counts the read still in flight.
  assign occ   = {1'b0, out_count} + {{CW{1'b0}}, s1_valid_r};
  assign space = (occ < (CW+1)'(OUT_DEPTH));

  // Row geometry for a new emit request.
  always_comb begin
    r_start = ({1'b0, out_row_r} >= cmd.height) ? '0 : out_row_r;
    r_div   = jbu_pkg::div_small(r_start, cmd.cv);
    blk     = RW'(cmd.ih) * RW'(r_start[4:3]);
  end

  // Column offset within the row.
  always_comb begin
    c_div    = jbu_pkg::div_small(col_r, ch_r);
    col_off  = rep_r ? {5'b00000, c_div} : {2'b00, col_r[4:3], 3'b000, col_r[2:0]};
    col_last = (({1'b0, col_r}) + SW'(1)) == width_r;
  end

  // Sequencer: idle loads, errors, row starts; emit one pixel a cycle if room.
  always_comb begin
    state_nxt        = state_r;
    load_ptr_nxt     = load_ptr_r;
    out_row_nxt      = out_row_r;
    row_nxt          = row_r;
    last_row_nxt     = last_row_r;
    width_nxt        = width_r;
    rep_nxt          = rep_r;
    ch_nxt           = ch_r;
    row_base_nxt     = row_base_r;
    col_nxt          = col_r;
    s1_valid_nxt     = 1'b0;
    s1_err_nxt       = 1'b0;
    s1_row_end_nxt   = 1'b0;
    s1_frame_end_nxt = 1'b0;
    cmd_pop          = 1'b0;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_raddr        = row_base_r + col_off;
    case (state_r)
      jbu_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          if (!cmd.is_emit) begin
            cmd_pop      = 1'b1;
            mem_we       = 1'b1;
            load_ptr_nxt = load_ptr_r + 1'b1;
          end else if (cmd.err) begin
            if (space) begin
              cmd_pop      = 1'b1;
              s1_valid_nxt = 1'b1;
              s1_err_nxt   = 1'b1;
            end
          end else begin
            cmd_pop      = 1'b1;
            row_nxt      = r_start;
            last_row_nxt = (({1'b0, r_start}) + SW'(1)) == cmd.height;
            width_nxt    = cmd.width;
            rep_nxt      = cmd.rep;
            ch_nxt       = cmd.ch;
            col_nxt      = '0;
            row_base_nxt = cmd.rep ? {2'b00, r_div, 3'b000}
                                   : {blk[3:0], r_start[2:0], 3'b000};
            state_nxt    = jbu_pkg::BK_EMIT;
          end
        end
      end
      jbu_pkg::BK_EMIT: begin
        if (space) begin
          mem_re           = 1'b1;
          s1_valid_nxt     = 1'b1;
          s1_row_end_nxt   = col_last;
          s1_frame_end_nxt = col_last && last_row_r;
          col_nxt          = col_r + 1'b1;
          if (col_last) begin
            state_nxt = jbu_pkg::BK_IDLE;
            if (last_row_r) begin
              out_row_nxt  = '0;
              load_ptr_nxt = '0;
            end else begin
              out_row_nxt = row_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = jbu_pkg::BK_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= jbu_pkg::BK_IDLE;
      load_ptr_r <= '0;
      out_row_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_ptr_r <= load_ptr_nxt;
      out_row_r  <= out_row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Row context and result flags travel without reset.
  always_ff @(posedge clk) begin
    row_r          <= row_nxt;
    last_row_r     <= last_row_nxt;
    width_r        <= width_nxt;
    rep_r          <= rep_nxt;
    ch_r           <= ch_nxt;
    row_base_r     <= row_base_nxt;
    col_r          <= col_nxt;
    s1_err_r       <= s1_err_nxt;
    s1_row_end_r   <= s1_row_end_nxt;
    s1_frame_end_r <= s1_frame_end_nxt;
  end

  // Pixel store: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[load_ptr_r] <= cmd.pixel;
    end
    if (mem_re) begin
      rdata_r <= store_r[mem_raddr];
    end
  end

  // Result beat into the result queue.
  assign out_push = s1_valid_r;
  always_comb begin
    out_item.pixel_out   = s1_err_r ? '0 : rdata_r;
    out_item.row_end     = s1_row_end_r;
    out_item.frame_end   = s1_frame_end_r;
    out_item.setup_error = s1_err_r;
  end

endmodule

// ===== design/jbu_checker.sv =====
// Port-level checks for the JPEG block upsampler, bound to the top level.
// Depends on jbu_pkg and jpeg_block_upsampler_core.
module jbu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               empty,
  input logic               pop,
  input jbu_pkg::out_item_t out_data
);

  // The result queue is empty in the cycle after reset.
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // A setup error beat carries no pixel and no row or frame marks.
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.setup_error) |->
      (out_data.pixel_out == '0 && !out_data.row_end && !out_data.frame_end))
    else $error("setup error beat carries pixel data");

  // The end of a frame is always the end of a row.
  a_frame_on_row: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.frame_end) |-> out_data.row_end)
    else $error("frame end without row end");

  // A waiting result that is not taken stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed before it was taken");

endmodule

bind jpeg_block_upsampler_core jbu_checker u_jbu_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
